FILE: hw/rtl/chained_hash_table_engine_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash table engine
// Concurrent checks that are compiled out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CHTE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHTE_ASSERT_SAME(label, clk, rst, ante, cons)
`define CHTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/chte_pkg.sv
// ---------------------------------------------------------------------------
// chte_pkg
// Types, constants and hash helpers of the chained hash table engine.
// ---------------------------------------------------------------------------
package chte_pkg;

   localparam int BUCKETS      = 1024;
   localparam int POOL_ENTRIES = 1024;
   localparam int ENTRIES      = BUCKETS + POOL_ENTRIES;
   localparam int KEY_BYTES    = 8;
   localparam int BUCKET_W     = 10;
   localparam int POOL_W       = 10;
   localparam int ENTRY_W      = 11;
   localparam int LINK_W       = 12;
   localparam int TOP_W        = 11;
   localparam int STEP_W       = 11;
   localparam int BC_W         = 11;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

   typedef enum logic [1:0] {
      OP_SEARCH = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_SUCCESS   = 3'd0,
      ST_EMPTY_KEY = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_POOL_FULL = 3'd4,
      ST_BAD_TYPE  = 3'd5
   } status_type;

   localparam logic [2:0] TYPE_INVALID = 3'd7;

   typedef struct packed {
      logic [2:0]  vtype;
      logic [3:0]  len;
      logic [63:0] value;
      logic [63:0] key;
   } entry_type;

   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_HASH,
      FSM_WALK_RD,
      FSM_WALK_CMP,
      FSM_DECIDE,
      FSM_POP,
      FSM_INS_POOL,
      FSM_INS_LINK,
      FSM_DEL_POOL,
      FSM_DEL_NULL,
      FSM_DONE
   } fsm_type;

   typedef enum logic [1:0] {
      HP_IDLE,
      HP_MIX,
      HP_FINAL,
      HP_DIV
   } hash_phase_type;

   typedef struct packed {
      logic        start;
      logic [63:0] key;
      logic [3:0]  len;
   } hash_req_type;

   typedef struct packed {
      logic                done;
      logic [BUCKET_W-1:0] bucket;
   } hash_rsp_type;

   function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + {24'd0, b};
      t = t + (t << 10);
      return t ^ (t >> 6);
   endfunction

   function automatic logic [30:0] hash_final(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t[30:0];
   endfunction

endpackage

FILE: hw/rtl/chte_ram.sv
// ---------------------------------------------------------------------------
// chte_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module chte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hw/rtl/chte_hash_unit.sv
// ---------------------------------------------------------------------------
// chte_hash_unit
// One-at-a-time hash, one key byte per cycle, then a bit-serial remainder.
// ---------------------------------------------------------------------------
module chte_hash_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  chte_pkg::hash_req_type        hreq,
   input  logic [chte_pkg::BC_W-1:0]     bucket_count,
   output chte_pkg::hash_rsp_type        hrsp
);
   import chte_pkg::*;

   hash_phase_type phase_ff, phase_in;
   logic [63:0]    key_ff, key_in;
   logic [3:0]     left_ff, left_in;
   logic [31:0]    h_ff, h_in;
   logic [4:0]     bit_ff, bit_in;
   logic [BC_W:0]  rem_ff, rem_in;
   logic           done_ff, done_in;
   logic [BC_W:0]  trial;

   always_comb begin
      phase_in = phase_ff;
      key_in   = key_ff;
      left_in  = left_ff;
      h_in     = h_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[BC_W-1:0], h_ff[bit_ff]};
      case (phase_ff)
         HP_IDLE: begin
            if (hreq.start) begin
               key_in   = hreq.key;
               left_in  = hreq.len;
               h_in     = '0;
               phase_in = (hreq.len == 4'd0) ? HP_FINAL : HP_MIX;
            end
         end
         HP_MIX: begin
            h_in    = hash_mix(h_ff, key_ff[7:0]);
            key_in  = key_ff >> 8;
            left_in = left_ff - 4'd1;
            if (left_ff == 4'd1) begin
               phase_in = HP_FINAL;
            end
         end
         HP_FINAL: begin
            h_in     = {1'b0, hash_final(h_ff)};
            bit_in   = 5'd30;
            rem_in   = '0;
            phase_in = HP_DIV;
         end
         HP_DIV: begin
            // Restoring remainder: the partial value always stays below twice the divisor.
            if (trial >= {1'b0, bucket_count}) begin
               rem_in = trial - {1'b0, bucket_count};
            end else begin
               rem_in = trial;
            end
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               done_in  = 1'b1;
               phase_in = HP_IDLE;
            end
         end
         default: phase_in = HP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      key_ff  <= key_in;
      left_ff <= left_in;
      h_ff    <= h_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
   end

   assign hrsp.done   = done_ff;
   assign hrsp.bucket = rem_ff[BUCKET_W-1:0];
endmodule

FILE: hw/rtl/chained_hash_table_engine_unit.sv
// ---------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Key-value table with primary bucket slots and chained overflow entries.
// ---------------------------------------------------------------------------
// After reset the block sweeps its entry memories and takes no request
// during that time. Requests are then handled one at a time. The hash
// mixes in the key bytes one at a time, finalizes, and then forms the
// bucket remainder bit by bit before handing the bucket over. The chain
// walk reads each visited entry from a synchronous RAM before it is
// compared, in the states WALK_RD and WALK_CMP. Deciding and issuing the
// response take the states DECIDE and DONE, after which the next request
// is taken. Inserts of pool entries add the write-back states POP, INS_POOL
// and INS_LINK, and deletes of pool entries DEL_POOL and DEL_NULL. A
// finished response waits in an output register while the next request is
// taken; DONE waits while that register is still full and not taken.
module chained_hash_table_engine_unit (
   input  logic          clock,
   input  logic          reset,
   // req_tdata, low to high: operation[1:0], key_bytes[65:2], key_length[69:66],
   // value_word[133:70], value_type[136:134], zero fill[143:137]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,
   // rsp_tdata, low to high: status[2:0], bucket_index[12:3], found_value[76:13],
   // found_type[79:77]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [79:0]   rsp_tdata,
   input  logic          csr_wen,
   input  logic [10:0]   csr_wdata
);
   import chte_pkg::*;

   fsm_type              state_ff, state_in;
   logic [BC_W-1:0]      bc_ff, bc_in;
   logic [ENTRY_W-1:0]   clr_ff, clr_in;
   logic [TOP_W-1:0]     top_ff, top_in;
   op_type               op_ff, op_in;
   logic [63:0]          key_ff, key_in;
   logic [3:0]           len_ff, len_in;
   logic [63:0]          value_ff, value_in;
   logic [2:0]           type_ff, type_in;
   logic [BUCKET_W-1:0]  bucket_ff, bucket_in;
   logic [LINK_W-1:0]    cur_ff, cur_in;
   logic [LINK_W-1:0]    prev_ff, prev_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [LINK_W-1:0]    match_ff, match_in;
   logic [LINK_W-1:0]    link_b_ff, link_b_in;
   logic [LINK_W-1:0]    link_e_ff, link_e_in;
   logic [3:0]           prim_len_ff, prim_len_in;
   logic                 hit_ff, hit_in;
   entry_type            found_ff, found_in;
   status_type           status_ff, status_in;
   logic [ENTRY_W-1:0]   newe_ff, newe_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [79:0]          rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic [3:0]           req_len;
   logic [63:0]          req_key;
   logic [63:0]          key_mask;
   hash_req_type         hreq;
   hash_rsp_type         hrsp;

   logic                 dwr_en, lwr_en, swr_en;
   logic [ENTRY_W-1:0]   dwr_addr, lwr_addr, drd_addr;
   entry_type            dwr_data, drd_data;
   logic [LINK_W-1:0]    lwr_data, lrd_data;
   logic [POOL_W-1:0]    swr_addr, swr_data, srd_addr, srd_data;
   logic                 is_search;
   logic [63:0]          out_value;
   logic [2:0]           out_type;

   assign req_tready = (state_ff == FSM_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Over-long keys count as full length; bytes past the length are dropped.
   assign req_len = (req_tdata[69:66] > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_tdata[69:66];
   always_comb begin
      for (int i = 0; i < KEY_BYTES; i++) begin
         key_mask[8*i +: 8] = (4'(i) < req_len) ? 8'hFF : 8'h00;
      end
   end
   assign req_key = req_tdata[65:2] & key_mask;

   assign hreq.start = req_accept;
   assign hreq.key   = req_key;
   assign hreq.len   = req_len;

   chte_hash_unit u_hash (
      .clock        (clock),
      .reset        (reset),
      .hreq         (hreq),
      .bucket_count (bc_ff),
      .hrsp         (hrsp)
   );

   chte_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (dwr_en),
      .wr_addr (dwr_addr),
      .wr_data (dwr_data),
      .rd_addr (drd_addr),
      .rd_data (drd_data)
   );

   chte_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (lwr_en),
      .wr_addr (lwr_addr),
      .wr_data (lwr_data),
      .rd_addr (drd_addr),
      .rd_data (lrd_data)
   );

   chte_ram #(.WIDTH(POOL_W), .DEPTH(POOL_ENTRIES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (swr_en),
      .wr_addr (swr_addr),
      .wr_data (swr_data),
      .rd_addr (srd_addr),
      .rd_data (srd_data)
   );

   assign is_search = (op_ff != OP_INSERT) && (op_ff != OP_DELETE);
   assign out_value = (is_search && status_ff == ST_SUCCESS) ? found_ff.value : 64'd0;
   assign out_type  = (is_search && status_ff == ST_SUCCESS) ? found_ff.vtype : 3'd0;

   always_comb begin
      bc_in = bc_ff;
      if (csr_wen) begin
         if (csr_wdata == '0) begin
            bc_in = BC_W'(1);
         end else if (csr_wdata > BC_W'(BUCKETS)) begin
            bc_in = BC_W'(BUCKETS);
         end else begin
            bc_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      top_in       = top_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      value_in     = value_ff;
      type_in      = type_ff;
      bucket_in    = bucket_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      match_in     = match_ff;
      link_b_in    = link_b_ff;
      link_e_in    = link_e_ff;
      prim_len_in  = prim_len_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      newe_in      = newe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      dwr_en       = 1'b0;
      dwr_addr     = match_ff[ENTRY_W-1:0];
      dwr_data     = found_ff;
      lwr_en       = 1'b0;
      lwr_addr     = match_ff[ENTRY_W-1:0];
      lwr_data     = NULL_LINK;
      swr_en       = 1'b0;
      swr_addr     = top_ff[POOL_W-1:0];
      swr_data     = match_ff[POOL_W-1:0];
      drd_addr     = cur_ff[ENTRY_W-1:0];
      srd_addr     = POOL_W'(top_ff - TOP_W'(1));
      case (state_ff)
         FSM_CLEAR: begin
            dwr_en   = 1'b1;
            dwr_addr = clr_ff;
            dwr_data = '0;
            lwr_en   = 1'b1;
            lwr_addr = clr_ff;
            lwr_data = NULL_LINK;
            swr_en   = (clr_ff < ENTRY_W'(POOL_ENTRIES));
            swr_addr = clr_ff[POOL_W-1:0];
            swr_data = clr_ff[POOL_W-1:0];
            clr_in   = clr_ff + ENTRY_W'(1);
            if (clr_ff == ENTRY_W'(ENTRIES - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_accept) begin
               op_in    = op_type'(req_tdata[1:0]);
               key_in   = req_key;
               len_in   = req_len;
               value_in = req_tdata[133:70];
               type_in  = req_tdata[136:134];
               state_in = FSM_HASH;
            end
         end
         FSM_HASH: begin
            if (hrsp.done) begin
               bucket_in = hrsp.bucket;
               cur_in    = {1'b0, 1'b0, hrsp.bucket};
               prev_in   = NULL_LINK;
               steps_in  = '0;
               hit_in    = 1'b0;
               if (len_ff == 4'd0) begin
                  status_in = ST_EMPTY_KEY;
                  state_in  = FSM_DONE;
               end else begin
                  state_in = FSM_WALK_RD;
               end
            end
         end
         FSM_WALK_RD: begin
            if (cur_ff >= NULL_LINK || steps_ff > STEP_W'(POOL_ENTRIES)) begin
               state_in = FSM_DECIDE;
            end else begin
               state_in = FSM_WALK_CMP;
            end
         end
         FSM_WALK_CMP: begin
            if (steps_ff == '0) begin
               prim_len_in = drd_data.len;
               link_b_in   = lrd_data;
            end
            if (drd_data.len == len_ff && drd_data.key == key_ff) begin
               hit_in    = 1'b1;
               match_in  = cur_ff;
               link_e_in = lrd_data;
               found_in  = drd_data;
               state_in  = FSM_DECIDE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = lrd_data;
               steps_in = steps_ff + STEP_W'(1);
               state_in = FSM_WALK_RD;
            end
         end
         FSM_DECIDE: begin
            state_in  = FSM_DONE;
            status_in = ST_SUCCESS;
            case (op_ff)
               OP_INSERT: begin
                  if (hit_ff) begin
                     status_in = ST_EXISTS;
                  end else if (prim_len_ff == 4'd0) begin
                     if (type_ff == TYPE_INVALID) begin
                        status_in = ST_BAD_TYPE;
                     end else begin
                        dwr_en   = 1'b1;
                        dwr_addr = {1'b0, bucket_ff};
                        dwr_data = '{vtype: type_ff, len: len_ff, value: value_ff,
                                     key: key_ff};
                     end
                  end else if (top_ff == '0) begin
                     status_in = ST_POOL_FULL;
                  end else if (type_ff == TYPE_INVALID) begin
                     status_in = ST_BAD_TYPE;
                  end else begin
                     state_in = FSM_POP;
                  end
               end
               OP_DELETE: begin
                  if (!hit_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     dwr_en       = 1'b1;
                     dwr_data     = found_ff;
                     dwr_data.len = 4'd0;
                     if (match_ff[ENTRY_W-1]) begin
                        state_in = FSM_DEL_POOL;
                     end
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     status_in = ST_NOT_FOUND;
                  end
               end
            endcase
         end
         FSM_POP: begin
            state_in = FSM_INS_POOL;
         end
         FSM_INS_POOL: begin
            newe_in  = {1'b1, srd_data};
            dwr_en   = 1'b1;
            dwr_addr = {1'b1, srd_data};
            dwr_data = '{vtype: type_ff, len: len_ff, value: value_ff, key: key_ff};
            lwr_en   = 1'b1;
            lwr_addr = {1'b1, srd_data};
            lwr_data = link_b_ff;
            top_in   = top_ff - TOP_W'(1);
            state_in = FSM_INS_LINK;
         end
         FSM_INS_LINK: begin
            lwr_en   = 1'b1;
            lwr_addr = {1'b0, bucket_ff};
            lwr_data = {1'b0, newe_ff};
            state_in = FSM_DONE;
         end
         FSM_DEL_POOL: begin
            // Unlink the entry from its predecessor and return it to the free stack.
            lwr_en   = (prev_ff < NULL_LINK);
            lwr_addr = prev_ff[ENTRY_W-1:0];
            lwr_data = link_e_ff;
            if (top_ff < TOP_W'(POOL_ENTRIES)) begin
               swr_en = 1'b1;
               top_in = top_ff + TOP_W'(1);
            end
            state_in = FSM_DEL_NULL;
         end
         FSM_DEL_NULL: begin
            lwr_en   = 1'b1;
            lwr_addr = match_ff[ENTRY_W-1:0];
            lwr_data = NULL_LINK;
            state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {out_type, out_value, bucket_ff, 3'(status_ff)};
               state_in     = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         top_ff       <= TOP_W'(POOL_ENTRIES);
         bc_ff        <= BC_W'(BUCKETS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         bc_ff        <= bc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      value_ff    <= value_in;
      type_ff     <= type_in;
      bucket_ff   <= bucket_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      match_ff    <= match_in;
      link_b_ff   <= link_b_in;
      link_e_ff   <= link_e_in;
      prim_len_ff <= prim_len_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      newe_ff     <= newe_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "chained_hash_table_engine_unit_macros.svh"

   `CHTE_ASSERT_SAME(a_top_bound, clock, reset, 1'b1, top_ff <= TOP_W'(POOL_ENTRIES))
   `CHTE_ASSERT_NEXT(a_accept_hash, clock, reset, req_accept, state_ff == FSM_HASH)
   `CHTE_ASSERT_SAME(a_hash_only_busy, clock, reset, hrsp.done, state_ff == FSM_HASH)
   `CHTE_ASSERT_SAME(a_bc_range, clock, reset, 1'b1, bc_ff != '0 && bc_ff <= BC_W'(BUCKETS))
endmodule

FILE: tb/sv/chained_hash_table_engine_unit_tb.sv
// ---------------------------------------------------------------------------
// Chained hash table engine testbench
// Drives search, insert and delete requests through the stream ports and
// compares every response with a behavioral table model held in the bench,
// across several bucket counts.
// ---------------------------------------------------------------------------
module chained_hash_table_engine_unit_tb;
   import chte_pkg::*;

   typedef struct packed {
      logic [2:0]  vtype;
      logic [63:0] value;
      logic [3:0]  len;
      logic [63:0] key;
      logic [1:0]  op;
   } request_type;

   typedef struct packed {
      logic [2:0]  ftype;
      logic [63:0] fvalue;
      logic [9:0]  bucket;
      logic [2:0]  status;
   } response_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [79:0]   rsp_tdata;
   logic          csr_wen;
   logic [10:0]   csr_wdata;

   chained_hash_table_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // Table model state.
   logic [63:0] tbl_key [ENTRIES];
   logic [63:0] tbl_value [ENTRIES];
   logic [3:0]  tbl_len [ENTRIES];
   logic [2:0]  tbl_type [ENTRIES];
   int          tbl_link [ENTRIES];
   int          free_stack [POOL_ENTRIES];
   int          free_top;
   int          buckets_in_use;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int           mismatch_count = 0;
   int           response_count = 0;
   int           idle_cycles;
   bit           quiet_phase;
   bit           hold_phase;
   bit           hold_done;
   int           send_gap;
   int           recv_gap;
   int           hold_off;

   function automatic logic [9:0] bucket_of(logic [63:0] key, int len);
      logic [31:0] h;
      h = 0;
      for (int i = 0; i < len; i++) begin
         h = h + {24'd0, key[8*i +: 8]};
         h = h + (h << 10);
         h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return 10'((h & 32'h7FFF_FFFF) % buckets_in_use);
   endfunction

   function automatic int find_entry(int b, logic [63:0] key, int len, output int prev);
      int cur;
      int steps;
      cur = b;
      prev = ENTRIES;
      steps = 0;
      while (cur < ENTRIES && steps <= POOL_ENTRIES) begin
         if (tbl_len[cur] == len && tbl_key[cur] == key) return cur;
         prev = cur;
         cur = tbl_link[cur];
         steps++;
      end
      prev = ENTRIES;
      return ENTRIES;
   endfunction

   function automatic void table_reset();
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_key[i] = 0;
         tbl_value[i] = 0;
         tbl_len[i] = 0;
         tbl_type[i] = 0;
         tbl_link[i] = ENTRIES;
      end
      for (int i = 0; i < POOL_ENTRIES; i++) free_stack[i] = i;
      free_top = POOL_ENTRIES;
      buckets_in_use = BUCKETS;
   endfunction

   function automatic response_type table_apply(request_type r);
      response_type rsp;
      int           len;
      logic [63:0]  key;
      int           b;
      int           e;
      int           prev;
      rsp = '0;
      len = (r.len > KEY_BYTES) ? KEY_BYTES : int'(r.len);
      key = (len >= 8) ? r.key : (r.key & ((64'd1 << (8 * len)) - 64'd1));
      b = bucket_of(key, len);
      rsp.bucket = b[9:0];
      rsp.status = ST_SUCCESS;
      if (len == 0) begin
         rsp.status = ST_EMPTY_KEY;
      end else if (r.op == OP_INSERT) begin
         e = find_entry(b, key, len, prev);
         if (e != ENTRIES) begin
            rsp.status = ST_EXISTS;
         end else if (tbl_len[b] == 0) begin
            if (r.vtype == TYPE_INVALID) rsp.status = ST_BAD_TYPE;
            else begin
               tbl_key[b] = key; tbl_value[b] = r.value;
               tbl_len[b] = 4'(len); tbl_type[b] = r.vtype;
            end
         end else if (free_top == 0) begin
            rsp.status = ST_POOL_FULL;
         end else if (r.vtype == TYPE_INVALID) begin
            rsp.status = ST_BAD_TYPE;
         end else begin
            free_top--;
            e = BUCKETS + free_stack[free_top];
            tbl_key[e] = key; tbl_value[e] = r.value;
            tbl_len[e] = 4'(len); tbl_type[e] = r.vtype;
            tbl_link[e] = tbl_link[b];
            tbl_link[b] = e;
         end
      end else if (r.op == OP_DELETE) begin
         e = find_entry(b, key, len, prev);
         if (e == ENTRIES) begin
            rsp.status = ST_NOT_FOUND;
         end else begin
            tbl_len[e] = 0;
            tbl_type[e] = 0;
            if (e >= BUCKETS) begin
               if (prev < ENTRIES) tbl_link[prev] = tbl_link[e];
               tbl_link[e] = ENTRIES;
               if (free_top < POOL_ENTRIES) begin
                  free_stack[free_top] = e - BUCKETS;
                  free_top++;
               end
            end
         end
      end else begin
         // The spare operation code is handled as a search.
         e = find_entry(b, key, len, prev);
         if (e == ENTRIES) rsp.status = ST_NOT_FOUND;
         else begin
            rsp.fvalue = tbl_value[e];
            rsp.ftype = tbl_type[e];
         end
      end
      return rsp;
   endfunction

   function automatic request_type make_request(logic [1:0] op, logic [63:0] key,
                                                logic [3:0] len, logic [2:0] vtype);
      request_type r;
      r.op = op;
      r.key = key;
      r.len = len;
      r.value = {$urandom, $urandom};
      r.vtype = vtype;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: offers queued requests, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(table_apply(request_type'(req_tdata[136:0])));
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_tdata <= {7'd0, pending_requests.pop_front()};
            req_tvalid <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: accepts responses with random stalls and checks them in order.
   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
         hold_off <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            response_count++;
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected response %h", got);
            end else begin
               want = expected_responses.pop_front();
               if (got.status !== want.status || got.bucket !== want.bucket ||
                   got.fvalue !== want.fvalue || got.ftype !== want.ftype) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: exp st=%0d bkt=%0d val=%h typ=%0d",
                              want.status, want.bucket, want.fvalue, want.ftype,
                              " got st=%0d bkt=%0d val=%h typ=%0d",
                              got.status, got.bucket, got.fvalue, got.ftype);
               end
            end
         end
         if (hold_phase && !hold_done) begin
            // Long hold-off while the sender keeps offering requests.
            hold_done <= 1'b1;
            hold_off <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 19);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d responses outstanding", expected_responses.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
      // A request just taken may still be in flight after the last response.
      repeat (80) @(posedge clock);
   endtask

   task automatic write_bucket_count(logic [10:0] count);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_wen <= 1'b0;
      buckets_in_use = (count == 0) ? 1 : ((count > BUCKETS) ? BUCKETS : int'(count));
   endtask

   // Random traffic: keys mostly drawn from a small set so that inserts, hits
   // and deletes meet each other often; some lengths and types are invalid.
   task automatic queue_random(int count, int key_span);
      logic [63:0] key;
      logic [3:0]  len;
      logic [1:0]  op;
      logic [2:0]  vtype;
      for (int i = 0; i < count; i++) begin
         len = 4'($urandom_range(1, 8));
         key = {$urandom, $urandom};
         if ($urandom_range(0, 9) != 0) begin
            key = 64'($urandom_range(0, key_span - 1)) * 64'h9E37_79B9_7F4A_7C15;
            len = 4'(1 + key[2:0]);
         end
         if ($urandom_range(0, 19) == 0) len = 4'($urandom_range(0, 15));
         op = 2'($urandom_range(0, 9) < 4 ? OP_INSERT : $urandom_range(0, 3));
         vtype = ($urandom_range(0, 9) == 0) ? TYPE_INVALID : 3'($urandom_range(0, 6));
         pending_requests.push_back(make_request(op, key, len, vtype));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      quiet_phase = 0;
      hold_phase = 0;
      table_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty key, extremes, every operation and the error paths other than a full pool.
      pending_requests.push_back(make_request(OP_INSERT, '1, 4'd0, 3'd0));
      pending_requests.push_back(make_request(OP_INSERT, '1, 4'd8, 3'd6));
      pending_requests.push_back(make_request(OP_INSERT, '1, 4'd15, 3'd1));
      pending_requests.push_back(make_request(OP_SEARCH, '1, 4'd12, 3'd0));
      pending_requests.push_back(make_request(OP_SPARE, '1, 4'd8, 3'd0));
      pending_requests.push_back(make_request(OP_INSERT, 64'h0, 4'd1, TYPE_INVALID));
      pending_requests.push_back(make_request(OP_INSERT, 64'hFFFF_FF00, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_SEARCH, 64'h5500, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_DELETE, 64'h0, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_DELETE, 64'h0, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_SEARCH, 64'h0, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_DELETE, '1, 4'd9, 3'd0));
      pending_requests.push_back(make_request(OP_SEARCH, 64'hAAAA_5555_AAAA_5555, 4'd8, 3'd7));
      wait_drained();

      // One bucket: every key collides, so the chain and the pool get used.
      write_bucket_count(11'd0);
      pending_requests.push_back(make_request(OP_INSERT, 64'h11, 4'd1, 3'd2));
      pending_requests.push_back(make_request(OP_INSERT, 64'h22, 4'd1, TYPE_INVALID));
      pending_requests.push_back(make_request(OP_INSERT, 64'h22, 4'd1, 3'd3));
      pending_requests.push_back(make_request(OP_INSERT, 64'h33, 4'd1, 3'd4));
      pending_requests.push_back(make_request(OP_SEARCH, 64'h22, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_DELETE, 64'h22, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_SEARCH, 64'h33, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_DELETE, 64'h11, 4'd1, 3'd0));
      pending_requests.push_back(make_request(OP_INSERT, 64'h44, 4'd1, 3'd5));
      pending_requests.push_back(make_request(OP_SEARCH, 64'h33, 4'd1, 3'd0));
      // Long receiver hold-off while requests keep coming.
      hold_phase = 1;
      queue_random(60, 24);
      wait_drained();

      write_bucket_count(11'd7);
      queue_random(250, 40);
      wait_drained();
      write_bucket_count(11'h7FF);
      queue_random(250, 300);
      wait_drained();
      write_bucket_count(11'd1024);
      queue_random(250, 60);
      wait_drained();
      write_bucket_count(11'd3);
      quiet_phase = 1;
      queue_random(200, 30);
      wait_drained();

      $display("Covered %0d responses over bucket counts 1, 3, 7 and 1024.", response_count);
      $display("Chains, pool reuse, error paths and a long receiver stall were exercised.");
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
